FILE: src/idc_pkg.sv
// shared types and constants for the id compaction hash map
// holds table sizes, memory word layouts, request structs and state/status codes
// no dependencies
package idc_pkg;

	localparam int MAX_ENTRIES = 1023;
	localparam int NUM_BUCKETS = MAX_ENTRIES + 1;
	localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
	localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int ID_W        = 32;
	localparam int NAME_W      = 10;

	localparam logic CMD_RENAME  = 1'b0;
	localparam logic CMD_REVERSE = 1'b1;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_INSERTED   = 2'd1,
		ST_FULL       = 2'd2,
		ST_UNASSIGNED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_REV
	} state_t;

	// chain pointer with its own valid bit
	typedef struct packed {
		logic                valid;
		logic [ENTRY_AW-1:0] ptr;
	} head_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		head_t           link;
	} entry_t;

	typedef struct packed {
		logic                rd_en;
		logic [BUCKET_W-1:0] rd_addr;
		logic                wr_en;
		logic [BUCKET_W-1:0] wr_addr;
		head_t               wr_data;
	} head_req_t;

	typedef struct packed {
		logic                rd_en;
		logic [ENTRY_AW-1:0] rd_addr;
		logic                wr_en;
		logic [ENTRY_AW-1:0] wr_addr;
		entry_t              wr_data;
	} entry_req_t;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} res_t;

endpackage

FILE: src/id_compaction_hash_map_core.sv
// top level of the id compaction hash map
// ties the head table, entry store and sequencer together with the result register
// depends on idc_pkg, idc_head_table, idc_entry_store, idc_ctrl
//
// Renames arbitrary 32-bit ids to dense names 0, 1, 2, ... in order of first
// appearance, and translates a name back to its id. After reset the block
// clears its 1024 bucket heads, one per cycle, and holds req_stall high until
// the clearing is done. Items are then handled one at a time. A reverse lookup
// reads the entry of an assigned name at accept and returns its id from that
// read. A rename reads the bucket head, then walks the chain one entry per
// cycle through the single read port of the entry memory until a match or the
// chain end, and on a miss inserts the id at the chain head unless the table is
// full. A finished result sits in the output register while the next item is
// accepted; a result that cannot leave because the previous one is still
// stalled holds the sequencer until it can.
module id_compaction_hash_map_core import idc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               cmd,
	input  logic [ID_W-1:0]    key_id,
	input  logic [NAME_W-1:0]  name_in,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [NAME_W-1:0]  result_name,
	output logic [ID_W-1:0]    result_id,
	output logic [COUNT_W-1:0] entry_count,
	output logic [1:0]         status
);

	head_req_t  head_req;
	head_t      head_rd_data;
	logic       clearing;
	entry_req_t entry_req;
	entry_t     entry_rd_data;
	logic       req_ready;
	logic       res_valid;
	res_t       res;
	logic       out_free;

	// output register
	logic               out_valid_q;
	logic [NAME_W-1:0]  name_q;
	logic [ID_W-1:0]    id_q;
	logic [COUNT_W-1:0] count_q;
	status_t            status_q;

	// bucket heads, cleared after reset
	idc_head_table u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (head_req),
		.rd_data  (head_rd_data),
		.clearing (clearing)
	);

	// ids and chain links, indexed by name
	idc_entry_store u_entry (
		.clk     (clk),
		.req     (entry_req),
		.rd_data (entry_rd_data)
	);

	// memory accesses are strictly sequenced: a write lands at the end of one
	// item and the next item's first read comes after it
	idc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.cmd           (cmd),
		.key_id        (key_id),
		.name_in       (name_in),
		.req_ready     (req_ready),
		.clearing      (clearing),
		.head_req      (head_req),
		.head_rd_data  (head_rd_data),
		.entry_req     (entry_req),
		.entry_rd_data (entry_rd_data),
		.out_free      (out_free),
		.res_valid     (res_valid),
		.res           (res)
	);

	assign req_stall = !req_ready;

	// the register can take a new item when empty or when its item leaves now
	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			name_q   <= res.name;
			id_q     <= res.id;
			count_q  <= res.count;
			status_q <= res.status;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign result_name = name_q;
	assign result_id   = id_q;
	assign entry_count = count_q;
	assign status      = status_q;

endmodule

FILE: src/idc_head_table.sv
// bucket head memory, one chain head pointer per bucket
// clears every bucket after reset, one bucket per cycle; uses idc_pkg
module idc_head_table import idc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  head_req_t req,
	output head_t     rd_data,
	output logic      clearing
);

	head_t               mem [NUM_BUCKETS];
	logic                busy_q;
	logic [BUCKET_W-1:0] clr_addr_q;
	logic                wr_en;
	logic [BUCKET_W-1:0] wr_addr;
	head_t               wr_data;
	head_t               rd_data_q;

	always_comb begin
		if (busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = req.wr_en;
			wr_addr = req.wr_addr;
			wr_data = req.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BUCKET_W'(NUM_BUCKETS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = busy_q;

endmodule

FILE: src/idc_entry_store.sv
// entry memory: stored id and chain link of each assigned name
// one write and one registered read per cycle; uses idc_pkg
module idc_entry_store import idc_pkg::*; (
	input  logic       clk,
	input  entry_req_t req,
	output entry_t     rd_data
);

	entry_t mem [MAX_ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/idc_ctrl.sv
// sequencer: head read, chain walk, insert and reverse lookup
// drives both memories and the entry count; uses idc_pkg
module idc_ctrl import idc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              cmd,
	input  logic [ID_W-1:0]   key_id,
	input  logic [NAME_W-1:0] name_in,
	output logic              req_ready,
	input  logic              clearing,
	output head_req_t         head_req,
	input  head_t             head_rd_data,
	output entry_req_t        entry_req,
	input  entry_t            entry_rd_data,
	input  logic              out_free,
	output logic              res_valid,
	output res_t              res
);

	state_t             state_q, state_d;
	logic [ID_W-1:0]    key_q;
	logic [NAME_W-1:0]  name_q;
	logic [ENTRY_AW-1:0] cur_q;
	head_t              head_q;
	logic [COUNT_W-1:0] count_q;

	logic  in_fire;
	logic  res_fire;
	logic  is_full;
	logic  key_match;
	logic  miss;
	head_t link_sel;

	assign in_fire   = req_valid && req_ready;
	assign res_fire  = res_valid && out_free;
	assign is_full   = count_q == COUNT_W'(MAX_ENTRIES);
	assign key_match = entry_rd_data.id == key_q;
	assign link_sel  = (state_q == S_HEAD) ? head_rd_data : head_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = (cmd == CMD_REVERSE) ? S_REV : S_HEAD;
				end
			end
			S_HEAD: begin
				if (head_rd_data.valid) begin
					state_d = S_WALK;
				end else if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (!key_match && entry_rd_data.link.valid) begin
					state_d = S_WALK;
				end else if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			S_REV: begin
				if (res_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		head_req   = '0;
		entry_req  = '0;
		res_valid  = 1'b0;
		res.name   = '0;
		res.id     = '0;
		res.count  = count_q;
		res.status = ST_FOUND;
		miss       = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = !clearing;
				// bucket is id modulo the bucket count, a power of two
				head_req.rd_en   = in_fire && (cmd == CMD_RENAME);
				head_req.rd_addr = key_id[BUCKET_W-1:0];
				entry_req.rd_en   = in_fire && (cmd == CMD_REVERSE) &&
				                    (COUNT_W'(name_in) < count_q);
				entry_req.rd_addr = ENTRY_AW'(name_in);
			end
			S_HEAD: begin
				if (head_rd_data.valid) begin
					entry_req.rd_en   = 1'b1;
					entry_req.rd_addr = head_rd_data.ptr;
				end else begin
					miss = 1'b1;
				end
			end
			S_WALK: begin
				if (key_match) begin
					res_valid  = 1'b1;
					res.name   = NAME_W'(cur_q);
					res.status = ST_FOUND;
				end else if (entry_rd_data.link.valid) begin
					entry_req.rd_en   = 1'b1;
					entry_req.rd_addr = entry_rd_data.link.ptr;
				end else begin
					miss = 1'b1;
				end
			end
			S_REV: begin
				res_valid = 1'b1;
				if (COUNT_W'(name_q) < count_q) begin
					res.id     = entry_rd_data.id;
					res.status = ST_FOUND;
				end else begin
					res.status = ST_UNASSIGNED;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase

		// id not in its chain: insert at the chain head unless the table is full
		if (miss) begin
			res_valid = 1'b1;
			if (is_full) begin
				res.status = ST_FULL;
			end else begin
				res.status = ST_INSERTED;
				res.name   = NAME_W'(count_q);
				res.count  = count_q + 1'b1;
				head_req.wr_en          = res_fire;
				head_req.wr_addr        = key_q[BUCKET_W-1:0];
				head_req.wr_data.valid  = 1'b1;
				head_req.wr_data.ptr    = ENTRY_AW'(count_q);
				entry_req.wr_en         = res_fire;
				entry_req.wr_addr       = ENTRY_AW'(count_q);
				entry_req.wr_data.id    = key_q;
				entry_req.wr_data.link  = link_sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (entry_req.wr_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q  <= key_id;
			name_q <= name_in;
		end
		if (state_q == S_HEAD) begin
			head_q <= head_rd_data;
		end
		if (entry_req.rd_en) begin
			cur_q <= entry_req.rd_addr;
		end
	end

	a_insert_pair: assert property (@(posedge clk) disable iff (!arst_n)
		head_req.wr_en |-> entry_req.wr_en && head_req.wr_data.ptr == entry_req.wr_addr)
		else $error("head and entry writes of an insert disagree");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		entry_req.wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("entry count did not advance on insert");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !head_req.rd_en && !head_req.wr_en && !req_ready)
		else $error("head table accessed during clearing pass");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		is_full |-> !entry_req.wr_en)
		else $error("insert into a full table");

endmodule
